[design/att_pkg.sv]
package att_pkg;

  typedef enum logic [1:0] {
    OP_SET      = 2'd0,
    OP_DELETE   = 2'd1,
    OP_DISPATCH = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_HANDLE = 2'd0,
    KIND_RELOAD = 2'd1,
    KIND_FIRED  = 2'd2,
    KIND_SPARE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_FREE  = 2'd0,
    ST_ARMED = 2'd1,
    ST_TRIG  = 2'd2,
    ST_PTRIG = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SET_SCAN,
    S_SET_RES,
    S_DEL,
    S_DSP_RD,
    S_DSP_EVAL,
    S_DSP_MOD,
    S_DSP_WR,
    S_DSP_RELOAD,
    S_FIRE_RD,
    S_FIRE_OUT
  } state_e;

  localparam int unsigned OUT_HANDLE_W = 5;
  localparam int unsigned TAG_W        = 32;
  localparam int unsigned OUT_TIME_W   = 32;

endpackage

[design/att_divu.sv]
module att_divu #(
  parameter int unsigned W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] rem_o
);
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  div_q, div_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          busy_dly_q;
  logic [W:0]    trial;
  logic [W:0]    shifted;

  assign shifted = {rem_q, quo_q[W-1]};
  assign trial   = shifted - {1'b0, div_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
      cnt_d  = CW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // one quotient bit per cycle, restoring form
      if (!trial[W]) begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = shifted[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      busy_dly_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      busy_q     <= busy_d;
      busy_dly_q <= busy_q;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign rem_o = rem_q;
  // pulses the cycle after the last step
  assign done_o = busy_dly_q && !busy_q;
endmodule

[design/att_row_mem.sv]
module att_row_mem #(
  parameter int unsigned ROWS = 32,
  parameter int unsigned TW   = 32
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [$clog2(ROWS)-1:0] waddr_i,
  input  logic [TW-1:0]           wrem_i,
  input  logic [TW-1:0]           wper_i,
  input  logic [31:0]             wtag_i,
  input  logic                    wfull_i,
  input  logic [$clog2(ROWS)-1:0] raddr_i,
  output logic [TW-1:0]           rrem_o,
  output logic [TW-1:0]           rper_o,
  output logic [31:0]             rtag_o
);
  logic [TW-1:0] rem_mem [ROWS];
  logic [TW-1:0] per_mem [ROWS];
  logic [31:0]   tag_mem [ROWS];

  // a partial write touches the remaining count only
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      rem_mem[waddr_i] <= wrem_i;
      if (wfull_i) begin
        per_mem[waddr_i] <= wper_i;
        tag_mem[waddr_i] <= wtag_i;
      end
    end
    rrem_o <= rem_mem[raddr_i];
    rper_o <= per_mem[raddr_i];
    rtag_o <= tag_mem[raddr_i];
  end
endmodule

[design/alarm_table_timer.sv]
// Alarm table timer: one item (set, delete, dispatch) at a time; the receiver cannot stall.
// Set: scans rows from row 0 for a free row, then gives a reload result if the
// sleep budget shrinks, and the handle result. Delete: no result. Dispatch: reads
// each used row, runs the divider for each fired periodic row, then gives the reload
// and one result per fired row. The next item is taken in the first cycle with busy low.
// Reset clears row status, the use count and sets the sleep budget to all ones.
module alarm_table_timer #(
  parameter int unsigned ALARM_ROWS = 32,
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op_i,
  input  logic [31:0] alarm_tag_i,
  input  logic [31:0] delay_i,
  input  logic [31:0] period_i,
  input  logic        has_action_i,
  input  logic [5:0]  target_handle_i,
  input  logic [31:0] elapsed_i,
  output logic        result_valid_o,
  output logic [1:0]  kind_o,
  output logic [4:0]  handle_o,
  output logic        handle_valid_o,
  output logic [31:0] fired_tag_o,
  output logic [31:0] reload_value_o,
  output logic        last_o
);
  localparam int unsigned AW    = $clog2(ALARM_ROWS);
  localparam int unsigned CW    = $clog2(ALARM_ROWS + 1);
  localparam int unsigned TW    = TIME_WIDTH;
  localparam int unsigned OUT_H = att_pkg::OUT_HANDLE_W;
  // wide enough for both the handle field and the row count
  localparam int unsigned TGW   = (CW > 6) ? CW : 6;

  att_pkg::state_e state_q, state_d;

  // row status lives in flip-flops so that reset frees every row at once
  logic [1:0]    status_q [ALARM_ROWS];
  logic [CW-1:0] in_use_q, in_use_d;
  logic [TW-1:0] budget_q, budget_d;
  logic [CW-1:0] row_q, row_d;
  logic [TW-1:0] next_q, next_d;
  logic [TW-1:0] real_q, real_d;
  logic          reload_pend_q, reload_pend_d;

  // latched item
  logic [31:0] tag_q, delay_q, period_q, elapsed_q;
  logic        action_q;
  logic [5:0]  target_q;

  logic [TW-1:0] delay_t, period_t, elapsed_t;
  assign delay_t   = TW'(delay_q);
  assign period_t  = TW'(period_q);
  assign elapsed_t = TW'(elapsed_q);

  logic [AW-1:0] row_a;
  assign row_a = row_q[AW-1:0];

  // memory port
  logic          we;
  logic          wfull;
  logic [TW-1:0] wrem;
  logic [AW-1:0] raddr;
  logic [TW-1:0] rrem, rper;
  logic [31:0]   rtag;

  att_row_mem #(.ROWS(ALARM_ROWS), .TW(TW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (row_a),
    .wrem_i  (wrem),
    .wper_i  (period_t),
    .wtag_i  (tag_q),
    .wfull_i (wfull),
    .raddr_i (raddr),
    .rrem_o  (rrem),
    .rper_o  (rper),
    .rtag_o  (rtag)
  );

  logic          div_start, div_done;
  logic [TW-1:0] div_rem;
  att_divu #(.W(TW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (elapsed_t),
    .divisor_i  (rper),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  logic          accept;
  logic          scan_end;
  logic          row_free;
  logic          del_hit;
  logic [TW-1:0] due_new;
  logic [TW-1:0] rearm;
  logic [TW-1:0] counted;
  logic          set_shorten;

  assign accept   = start && !busy;
  assign scan_end = (row_q == in_use_q) || (row_q == CW'(ALARM_ROWS));
  assign row_free = (row_q < CW'(ALARM_ROWS)) &&
                    (status_q[row_a] == att_pkg::ST_FREE);
  assign del_hit  = TGW'(target_q) < TGW'(ALARM_ROWS);
  assign due_new  = delay_t + elapsed_t;
  assign rearm    = rper - div_rem;
  assign counted  = rrem - real_q;
  assign set_shorten = (budget_q > elapsed_t) && ((budget_q - elapsed_t) > delay_t);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      att_pkg::S_IDLE: begin
        if (accept) begin
          unique case (att_pkg::op_e'(op_i))
            att_pkg::OP_SET:      state_d = att_pkg::S_SET_SCAN;
            att_pkg::OP_DELETE:   state_d = att_pkg::S_DEL;
            att_pkg::OP_DISPATCH: state_d = att_pkg::S_DSP_RD;
            default:              state_d = att_pkg::S_IDLE;
          endcase
        end
      end
      att_pkg::S_SET_SCAN: begin
        if (!action_q || row_free || scan_end) state_d = att_pkg::S_SET_RES;
      end
      att_pkg::S_SET_RES: begin
        if (!reload_pend_q) state_d = att_pkg::S_IDLE;
      end
      att_pkg::S_DEL: state_d = att_pkg::S_IDLE;
      att_pkg::S_DSP_RD: begin
        if (row_q >= in_use_q || row_q == CW'(ALARM_ROWS)) state_d = att_pkg::S_DSP_RELOAD;
        else if (status_q[row_a][0]) state_d = att_pkg::S_DSP_EVAL;
      end
      att_pkg::S_DSP_EVAL: begin
        if (rrem <= real_q && rper != '0) state_d = att_pkg::S_DSP_MOD;
        else state_d = att_pkg::S_DSP_RD;
      end
      att_pkg::S_DSP_MOD: begin
        if (div_done) state_d = att_pkg::S_DSP_WR;
      end
      att_pkg::S_DSP_WR: state_d = att_pkg::S_DSP_RD;
      att_pkg::S_DSP_RELOAD: state_d = att_pkg::S_FIRE_RD;
      att_pkg::S_FIRE_RD: begin
        if (row_q >= in_use_q || row_q == CW'(ALARM_ROWS)) state_d = att_pkg::S_IDLE;
        else if (status_q[row_a][1]) state_d = att_pkg::S_FIRE_OUT;
      end
      att_pkg::S_FIRE_OUT: state_d = att_pkg::S_FIRE_RD;
      default: state_d = att_pkg::S_IDLE;
    endcase
  end

  // find whether any fired row follows the given one (for last)
  logic more_fired;
  always_comb begin
    more_fired = 1'b0;
    for (int i = 0; i < ALARM_ROWS; i++) begin
      if (CW'(i) > row_q && CW'(i) < in_use_q && status_q[i][1]) more_fired = 1'b1;
    end
  end

  // any fired row at all, for last on the reload
  logic more_any;
  always_comb begin
    more_any = 1'b0;
    for (int i = 0; i < ALARM_ROWS; i++) begin
      if (CW'(i) < in_use_q && status_q[i][1]) more_any = 1'b1;
    end
  end

  // outputs and datapath
  always_comb begin
    in_use_d      = in_use_q;
    budget_d      = budget_q;
    row_d         = row_q;
    next_d        = next_q;
    real_d        = real_q;
    reload_pend_d = reload_pend_q;
    we            = 1'b0;
    wfull         = 1'b0;
    wrem          = rrem;
    raddr         = row_a;
    div_start     = 1'b0;
    busy          = (state_q != att_pkg::S_IDLE);
    result_valid_o = 1'b0;
    kind_o         = att_pkg::KIND_HANDLE;
    handle_o       = '0;
    handle_valid_o = 1'b0;
    fired_tag_o    = '0;
    reload_value_o = '0;
    last_o         = 1'b0;
    unique case (state_q)
      att_pkg::S_IDLE: begin
        row_d = '0;
        if (accept) begin
          real_d = budget_q + TW'(elapsed_i);
          next_d = '1;
        end
      end
      att_pkg::S_SET_SCAN: begin
        if (!action_q || scan_end && !row_free) begin
          row_d = CW'(ALARM_ROWS);
        end else if (row_free) begin
          if (row_q == in_use_q) in_use_d = in_use_q + 1'b1;
          reload_pend_d = set_shorten;
          if (set_shorten) budget_d = due_new;
          we    = 1'b1;
          wfull = 1'b1;
          wrem  = due_new;
        end else begin
          row_d = row_q + 1'b1;
        end
      end
      att_pkg::S_SET_RES: begin
        result_valid_o = 1'b1;
        if (reload_pend_q) begin
          kind_o         = att_pkg::KIND_RELOAD;
          reload_value_o = 32'(delay_t);
          reload_pend_d  = 1'b0;
        end else begin
          last_o = 1'b1;
          if (row_q < CW'(ALARM_ROWS)) begin
            handle_o       = OUT_H'(row_q);
            handle_valid_o = 1'b1;
          end
        end
      end
      att_pkg::S_DEL: begin
        if (del_hit) begin
          if (in_use_q != '0 && CW'(target_q) == in_use_q - 1'b1) in_use_d = in_use_q - 1'b1;
        end
      end
      att_pkg::S_DSP_RD: begin
        if (!(row_q >= in_use_q || row_q == CW'(ALARM_ROWS)) && !status_q[row_a][0])
          row_d = row_q + 1'b1;
      end
      att_pkg::S_DSP_EVAL: begin
        if (rrem <= real_q) begin
          if (rper != '0) div_start = 1'b1;
          else row_d = row_q + 1'b1;
        end else begin
          we    = 1'b1;
          wrem  = counted;
          if (counted < next_q) next_d = counted;
          row_d = row_q + 1'b1;
        end
      end
      att_pkg::S_DSP_MOD: ;
      att_pkg::S_DSP_WR: begin
        we   = 1'b1;
        wrem = rearm;
        if (rearm < next_q) next_d = rearm;
        row_d = row_q + 1'b1;
      end
      att_pkg::S_DSP_RELOAD: begin
        result_valid_o = 1'b1;
        kind_o         = att_pkg::KIND_RELOAD;
        reload_value_o = 32'(next_q);
        budget_d       = next_q;
        row_d          = '0;
        last_o         = !more_any;
      end
      att_pkg::S_FIRE_RD: begin
        if (!(row_q >= in_use_q || row_q == CW'(ALARM_ROWS)) && !status_q[row_a][1])
          row_d = row_q + 1'b1;
      end
      att_pkg::S_FIRE_OUT: begin
        result_valid_o = 1'b1;
        kind_o         = att_pkg::KIND_FIRED;
        handle_o       = OUT_H'(row_q);
        handle_valid_o = 1'b1;
        fired_tag_o    = rtag;
        last_o         = !more_fired;
        row_d          = row_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= att_pkg::S_IDLE;
      in_use_q      <= '0;
      budget_q      <= '1;
      row_q         <= '0;
      reload_pend_q <= 1'b0;
      for (int i = 0; i < ALARM_ROWS; i++) status_q[i] <= att_pkg::ST_FREE;
    end else begin
      state_q       <= state_d;
      in_use_q      <= in_use_d;
      budget_q      <= budget_d;
      row_q         <= row_d;
      reload_pend_q <= reload_pend_d;
      // status updates: arm on set, free on delete, mark on dispatch, clear on fire
      if (state_q == att_pkg::S_SET_SCAN && action_q && row_free)
        status_q[row_a] <= att_pkg::ST_ARMED;
      if (state_q == att_pkg::S_DEL && del_hit)
        status_q[AW'(target_q)] <= att_pkg::ST_FREE;
      if (state_q == att_pkg::S_DSP_EVAL && rrem <= real_q && rper == '0)
        status_q[row_a] <= att_pkg::ST_TRIG;
      if (state_q == att_pkg::S_DSP_WR)
        status_q[row_a] <= att_pkg::ST_PTRIG;
      if (state_q == att_pkg::S_FIRE_OUT)
        status_q[row_a] <= {1'b0, status_q[row_a][0]};
    end
  end

  always_ff @(posedge clk_i) begin
    next_q <= next_d;
    real_q <= real_d;
    if (accept) begin
      tag_q     <= alarm_tag_i;
      delay_q   <= delay_i;
      period_q  <= period_i;
      action_q  <= has_action_i;
      target_q  <= target_handle_i;
      elapsed_q <= elapsed_i;
    end
  end
endmodule
